[rtl/lr_pkg.sv]
package lr_pkg;

  localparam int COORD_W = 10;
  localparam int COLOR_W = 8;
  localparam int DEC_W   = COORD_W + 2;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } lr_op_t;

  typedef struct packed {
    lr_op_t               operation;
    logic [COORD_W-1:0]   x_start;
    logic [COORD_W-1:0]   y_start;
    logic [COORD_W-1:0]   x_end;
    logic [COORD_W-1:0]   y_end;
    logic [COLOR_W-1:0]   color;
  } lr_in_t;

  typedef struct packed {
    logic                 pixel_valid;
    logic [COORD_W-1:0]   pixel_x;
    logic [COORD_W-1:0]   pixel_y;
    logic [COLOR_W-1:0]   pixel_color;
    logic                 last_pixel;
  } lr_out_t;

  typedef struct packed {
    logic [COORD_W-1:0]   pos_x;
    logic [COORD_W-1:0]   pos_y;
    logic [COORD_W-1:0]   target_x;
    logic [COORD_W-1:0]   target_y;
    logic [COORD_W-1:0]   span_x;
    logic [COORD_W-1:0]   span_y;
    logic                 x_negative;
    logic                 y_negative;
    logic signed [DEC_W-1:0] decision;
    logic [COLOR_W-1:0]   line_color;
    logic                 busy;
  } lr_state_t;

endpackage

[rtl/line_rasterizer.sv]
// output: an accepted beat's result is registered and on out_ the next cycle
// throughput: one beat per cycle unless out_stall holds a full result reg;
//   one pixel per advance beat while a line is busy, via the bresenham step
// reset: rst_n synchronous, active low; clears the line state (idle, no line)
//   and empties the result register
module line_rasterizer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  lr_pkg::lr_in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output lr_pkg::lr_out_t  out_data
);
  import lr_pkg::*;

  lr_state_t state_r;
  lr_state_t state_nxt;
  lr_out_t   result_nxt;
  lr_out_t   out_data_r;
  logic      out_valid_r;
  logic      in_take;

  // every beat in yields exactly one beat out, so the input only waits
  // while the result register is full and the far side holds it
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  // next line state and pixel for the current beat
  lr_step u_step (
    .cur    (state_r),
    .item   (in_data),
    .nxt    (state_nxt),
    .result (result_nxt)
  );

  // line state advances only on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_take) begin
      state_r <= state_nxt;
    end
  end

  // result register, refilled in the same cycle it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/lr_step.sv]
module lr_step (
  input  lr_pkg::lr_state_t cur,
  input  lr_pkg::lr_in_t    item,
  output lr_pkg::lr_state_t nxt,
  output lr_pkg::lr_out_t   result
);
  import lr_pkg::*;

  logic                    xneg_s;
  logic                    yneg_s;
  logic [COORD_W-1:0]      sx_s;
  logic [COORD_W-1:0]      sy_s;
  logic signed [DEC_W-1:0] two_sx;
  logic signed [DEC_W-1:0] two_sy;
  logic signed [DEC_W-1:0] sx_ext;
  logic signed [DEC_W-1:0] sy_ext;
  logic                    x_major;
  logic                    dec_pos;
  logic [COORD_W-1:0]      step_x;
  logic [COORD_W-1:0]      step_y;

  // start-of-line spans and directions
  assign xneg_s = item.x_end < item.x_start;
  assign yneg_s = item.y_end < item.y_start;
  assign sx_s   = xneg_s ? (item.x_start - item.x_end) : (item.x_end - item.x_start);
  assign sy_s   = yneg_s ? (item.y_start - item.y_end) : (item.y_end - item.y_start);

  // decision arithmetic, operands picked from the new line on start
  always_comb begin
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    sx = (item.operation == OP_START) ? sx_s : cur.span_x;
    sy = (item.operation == OP_START) ? sy_s : cur.span_y;
    sx_ext = $signed({2'b00, sx});
    sy_ext = $signed({2'b00, sy});
    two_sx = $signed({1'b0, sx, 1'b0});
    two_sy = $signed({1'b0, sy, 1'b0});
    x_major = sx >= sy;
  end

  assign dec_pos = !cur.decision[DEC_W-1] && (cur.decision != '0);
  assign step_x  = cur.x_negative ? (cur.pos_x - COORD_W'(1)) : (cur.pos_x + COORD_W'(1));
  assign step_y  = cur.y_negative ? (cur.pos_y - COORD_W'(1)) : (cur.pos_y + COORD_W'(1));

  always_comb begin
    nxt    = cur;
    result = '0;
    unique case (item.operation)
      OP_START: begin
        nxt.pos_x      = item.x_start;
        nxt.pos_y      = item.y_start;
        nxt.target_x   = item.x_end;
        nxt.target_y   = item.y_end;
        nxt.span_x     = sx_s;
        nxt.span_y     = sy_s;
        nxt.x_negative = xneg_s;
        nxt.y_negative = yneg_s;
        nxt.line_color = item.color;
        nxt.decision   = x_major ? (two_sy - sx_ext) : (two_sx - sy_ext);
        nxt.busy       = (sx_s != '0) || (sy_s != '0);
        result.pixel_valid = 1'b1;
        result.pixel_x     = item.x_start;
        result.pixel_y     = item.y_start;
        result.pixel_color = item.color;
        result.last_pixel  = !nxt.busy;
      end
      OP_ADVANCE: begin
        if (cur.busy) begin
          if (x_major) begin
            nxt.pos_x = step_x;
            if (dec_pos) begin
              nxt.pos_y    = step_y;
              nxt.decision = cur.decision + two_sy - two_sx;
            end else begin
              nxt.decision = cur.decision + two_sy;
            end
          end else begin
            nxt.pos_y = step_y;
            if (dec_pos) begin
              nxt.pos_x    = step_x;
              nxt.decision = cur.decision + two_sx - two_sy;
            end else begin
              nxt.decision = cur.decision + two_sx;
            end
          end
          nxt.busy = !((nxt.pos_x == cur.target_x) && (nxt.pos_y == cur.target_y));
          result.pixel_valid = 1'b1;
          result.pixel_x     = nxt.pos_x;
          result.pixel_y     = nxt.pos_y;
          result.pixel_color = cur.line_color;
          result.last_pixel  = !nxt.busy;
        end
      end
      default: begin
        nxt    = cur;
        result = '0;
      end
    endcase
  end

endmodule

[test/line_rasterizer_tb.sv]
`timescale 1ns / 1ps

module line_rasterizer_tb;
  import lr_pkg::*;

  localparam int RANDOM_BEATS   = 1300;
  localparam int CALM_TAIL      = 150;  // beats at the end with no idling on either side
  localparam int DRAIN_EVERY    = 400;
  localparam int WATCHDOG_LIMIT = 200;  // cycles with no beat on either channel

  // one stimulus row: the beat, and where it can be read off directly, the typed result
  typedef struct {
    lr_in_t  beat;
    bit      typed;
    lr_out_t want;
    bit      drain_first;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst_n;
  logic    in_valid;
  logic    in_stall;
  lr_in_t  in_data;
  logic    out_valid;
  logic    out_stall = 1'b0;
  lr_out_t out_data;

  stim_row_t stim_q[$];
  lr_out_t   pixel_q[$];     // pixels still owed by the block, oldest first
  int        accepted = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        stall_left = 0;
  bit        calm = 1'b0;
  bit        idling_on = 1'b1;

  // predictor's own copy of the line state
  logic [COORD_W-1:0] cur_x, cur_y, end_x, end_y, run_x, run_y;
  logic               neg_x, neg_y, drawing;
  logic [COLOR_W-1:0] pen_color;
  int                 err_term;

  line_rasterizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [COORD_W-1:0] nudge(logic [COORD_W-1:0] c, logic neg);
    return neg ? c - COORD_W'(1) : c + COORD_W'(1);
  endfunction

  // bresenham step over the predictor state, one pixel beat per input beat
  function automatic lr_out_t raster_step(lr_in_t b);
    lr_out_t px;
    px = '0;
    if (b.operation == OP_START) begin
      cur_x     = b.x_start;
      cur_y     = b.y_start;
      end_x     = b.x_end;
      end_y     = b.y_end;
      pen_color = b.color;
      neg_x     = b.x_end < b.x_start;
      neg_y     = b.y_end < b.y_start;
      run_x     = neg_x ? b.x_start - b.x_end : b.x_end - b.x_start;
      run_y     = neg_y ? b.y_start - b.y_end : b.y_end - b.y_start;
      // ties go to x as the major axis
      if (run_x >= run_y) err_term = 2 * int'(run_y) - int'(run_x);
      else err_term = 2 * int'(run_x) - int'(run_y);
      drawing = (run_x != '0) || (run_y != '0);
    end else begin
      // advance with no line in progress gives an all-zero beat
      if (!drawing) return px;
      if (run_x >= run_y) begin
        cur_x = nudge(cur_x, neg_x);
        // a decision of exactly zero keeps the minor axis
        if (err_term > 0) begin
          cur_y = nudge(cur_y, neg_y);
          err_term += 2 * (int'(run_y) - int'(run_x));
        end else begin
          err_term += 2 * int'(run_y);
        end
      end else begin
        cur_y = nudge(cur_y, neg_y);
        if (err_term > 0) begin
          cur_x = nudge(cur_x, neg_x);
          err_term += 2 * (int'(run_x) - int'(run_y));
        end else begin
          err_term += 2 * int'(run_x);
        end
      end
      if (cur_x == end_x && cur_y == end_y) drawing = 1'b0;
    end
    px.pixel_valid = 1'b1;
    px.pixel_x     = cur_x;
    px.pixel_y     = cur_y;
    px.pixel_color = pen_color;
    px.last_pixel  = !drawing;
    return px;
  endfunction

  function automatic lr_in_t noise_beat();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[$bits(lr_in_t)-1:0];
  endfunction

  function automatic void add_row(lr_op_t op, int xs, int ys, int xe, int ye, int col);
    stim_row_t s;
    s.beat.operation = op;
    s.beat.x_start   = COORD_W'(xs);
    s.beat.y_start   = COORD_W'(ys);
    s.beat.x_end     = COORD_W'(xe);
    s.beat.y_end     = COORD_W'(ye);
    s.beat.color     = COLOR_W'(col);
    s.typed          = 1'b0;
    s.want           = '0;
    s.drain_first    = 1'b0;
    stim_q.push_back(s);
  endfunction

  // pins the result of the row just added
  function automatic void typed_as(bit v, int px, int py, int pc, bit lp);
    int k;
    k = stim_q.size() - 1;
    stim_q[k].typed            = 1'b1;
    stim_q[k].want.pixel_valid = v;
    stim_q[k].want.pixel_x     = COORD_W'(px);
    stim_q[k].want.pixel_y     = COORD_W'(py);
    stim_q[k].want.pixel_color = COLOR_W'(pc);
    stim_q[k].want.last_pixel  = lp;
  endfunction

  // sender: builds the stimulus, then drives one beat at a time at the falling edge
  initial begin
    stim_row_t s;
    lr_in_t    b;
    int        n_dir, ex, ey, sx, sy, n, n_adv, pick;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;

    // directed part
    add_row(OP_ADVANCE, 0, 0, 0, 0, 0);               typed_as(0, 0, 0, 0, 0);
    add_row(OP_START, 0, 0, 0, 0, 0);                 typed_as(1, 0, 0, 0, 1);
    add_row(OP_START, 1023, 1023, 1023, 1023, 255);   typed_as(1, 1023, 1023, 255, 1);
    add_row(OP_ADVANCE, 0, 0, 0, 0, 0);               typed_as(0, 0, 0, 0, 0);
    add_row(OP_START, 0, 0, 1023, 1023, 'hAA);        typed_as(1, 0, 0, 'hAA, 0);
    add_row(OP_ADVANCE, 0, 0, 0, 0, 0);
    // start while busy abandons the diagonal
    add_row(OP_START, 1023, 0, 0, 1023, 'h55);        typed_as(1, 1023, 0, 'h55, 0);
    add_row(OP_ADVANCE, 0, 0, 0, 0, 0);
    // shallow line whose first decision is exactly zero
    add_row(OP_START, 0, 0, 4, 2, 'h0F);              typed_as(1, 0, 0, 'h0F, 0);
    repeat (4) add_row(OP_ADVANCE, 0, 0, 0, 0, 0);
    add_row(OP_ADVANCE, 0, 0, 0, 0, 0);               typed_as(0, 0, 0, 0, 0);
    // steep line stepping y downwards
    add_row(OP_START, 3, 6, 5, 0, 'hF0);              typed_as(1, 3, 6, 'hF0, 0);
    repeat (6) add_row(OP_ADVANCE, 0, 0, 0, 0, 0);
    // equal spans, x stepping downwards
    add_row(OP_START, 10, 10, 7, 13, 'h3C);           typed_as(1, 10, 10, 'h3C, 0);
    repeat (3) add_row(OP_ADVANCE, 0, 0, 0, 0, 0);
    n_dir = stim_q.size();

    // random part: mostly whole lines with random payload bits, some abandoned, some noise
    while (stim_q.size() < n_dir + RANDOM_BEATS) begin
      s.typed       = 1'b0;
      s.want        = '0;
      s.drain_first = 1'b0;
      if ($urandom_range(0, 99) < 8) begin
        s.beat = noise_beat();
        stim_q.push_back(s);
      end else begin
        b = noise_beat();
        b.operation = OP_START;
        if ($urandom_range(0, 9) != 0) begin
          // short line around a random start point
          ex = int'(b.x_start);
          ex += $urandom_range(0, 24);
          ex -= 12;
          ey = int'(b.y_start);
          ey += $urandom_range(0, 24);
          ey -= 12;
          if (ex < 0) ex = 0;
          if (ex > 1023) ex = 1023;
          if (ey < 0) ey = 0;
          if (ey > 1023) ey = 1023;
          b.x_end = COORD_W'(ex);
          b.y_end = COORD_W'(ey);
        end
        sx = (b.x_end > b.x_start) ? b.x_end - b.x_start : b.x_start - b.x_end;
        sy = (b.y_end > b.y_start) ? b.y_end - b.y_start : b.y_start - b.y_end;
        n  = (sx > sy) ? sx : sy;
        pick = $urandom_range(0, 99);
        if (n > 40 && pick < 90) n_adv = $urandom_range(0, 40);
        else if (pick < 15) n_adv = $urandom_range(0, n);
        else if (pick >= 90) n_adv = n + $urandom_range(1, 2);
        else n_adv = n;
        s.beat = b;
        stim_q.push_back(s);
        repeat (n_adv) begin
          s.beat = noise_beat();
          s.beat.operation = OP_ADVANCE;
          stim_q.push_back(s);
        end
      end
    end
    for (int i = n_dir; i < stim_q.size(); i += DRAIN_EVERY) stim_q[i].drain_first = 1'b1;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < stim_q.size(); i++) begin
      calm      = i >= stim_q.size() - CALM_TAIL;
      idling_on = !calm && ((i / 64) % 4 != 3);
      if (stim_q[i].drain_first) begin
        // hold off until every owed pixel has come back
        in_valid <= 1'b0;
        @(negedge clk);
        while (pixel_q.size() != 0) @(negedge clk);
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= stim_q[i].beat;
      do @(posedge clk); while (in_stall);
      @(negedge clk);
    end
    in_valid <= 1'b0;

    while (pixel_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // receiver stalls in short bursts while idling is on, none in the calm tail
  always @(negedge clk) begin
    if (calm) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // scoreboard: predict on each input beat, check each result beat against the oldest pixel
  always @(posedge clk) begin
    lr_out_t pred, w;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pred = raster_step(in_data);
        pixel_q.push_back(stim_q[accepted].typed ? stim_q[accepted].want : pred);
        accepted++;
      end
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: v=%0d x=%0d y=%0d c=%0h l=%0d",
                     out_data.pixel_valid, out_data.pixel_x, out_data.pixel_y,
                     out_data.pixel_color, out_data.last_pixel);
        end else begin
          w = pixel_q.pop_front();
          if (out_data.pixel_valid !== w.pixel_valid || out_data.pixel_x !== w.pixel_x ||
              out_data.pixel_y !== w.pixel_y || out_data.pixel_color !== w.pixel_color ||
              out_data.last_pixel !== w.last_pixel) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel mismatch: got v=%0d x=%0d y=%0d c=%0h l=%0d",
                       out_data.pixel_valid, out_data.pixel_x, out_data.pixel_y,
                       out_data.pixel_color, out_data.last_pixel,
                       ", want v=%0d x=%0d y=%0d c=%0h l=%0d",
                       w.pixel_valid, w.pixel_x, w.pixel_y, w.pixel_color, w.last_pixel);
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule
